// ===== rtl/sacrr_pkg.sv =====
// ----------------------------------------------------------------------------
// sacrr_pkg
// Shared types, constants and the LFSR step for the random-replacement cache.
// ----------------------------------------------------------------------------
`default_nettype none

package sacrr_pkg;

   // default geometry
   localparam int unsigned DEF_OFFSET_BITS  = 5;
   localparam int unsigned DEF_SET_BITS     = 6;
   localparam int unsigned DEF_WAYS         = 4;
   localparam int unsigned DEF_ADDRESS_BITS = 32;

   // fixed field widths
   localparam int unsigned ADDR_W    = 32;
   localparam int unsigned WAY_OUT_W = 2;
   localparam int unsigned COUNT_W   = 32;
   localparam int unsigned SEED_W    = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
   localparam logic [SEED_W-1:0]  SEED_RESET = SEED_W'(1);

   typedef logic [SEED_W-1:0] seed_type;

   typedef struct packed {
      logic     load;
      seed_type seed;
      logic     step;
   } lfsr_ctrl_type;

   // fibonacci step for x^16 + x^14 + x^13 + x^11 + 1
   function automatic seed_type lfsr_next(input seed_type l);
      logic fb;
      fb = l[0] ^ l[2] ^ l[3] ^ l[5];
      return {fb, l[SEED_W-1:1]};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sacrr_ram.sv =====
// ----------------------------------------------------------------------------
// sacrr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sacrr_ram #(
   parameter int unsigned DATA_W = 8,
   parameter int unsigned DEPTH  = 64,
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/sacrr_lfsr.sv =====
// ----------------------------------------------------------------------------
// sacrr_lfsr
// Replacement LFSR with seed load and the fill way for the next miss.
// ----------------------------------------------------------------------------
`default_nettype none

module sacrr_lfsr #(
   parameter int unsigned WAYS  = sacrr_pkg::DEF_WAYS,
   localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire sacrr_pkg::lfsr_ctrl_type ctrl,
   output logic [WAY_W-1:0]              fill_way
);

   localparam int unsigned LW    = sacrr_pkg::SEED_W;
   localparam int unsigned SUM_W = $clog2(LW * WAYS);
   localparam int unsigned LUT_N = 1 << SUM_W;

   sacrr_pkg::seed_type lfsr_ff, lfsr_in, lfsr_nx;
   logic [SUM_W-1:0]    bit_weight [LW];
   logic [WAY_W-1:0]    mod_lut [LUT_N];
   logic [SUM_W-1:0]    residue_sum;

   // residue of each bit position, and residue of the folded sum
   for (genvar i = 0; i < LW; i++) begin : g_weight
      assign bit_weight[i] = SUM_W'((1 << i) % WAYS);
   end
   for (genvar j = 0; j < LUT_N; j++) begin : g_lut
      assign mod_lut[j] = WAY_W'(j % WAYS);
   end

   assign lfsr_nx = sacrr_pkg::lfsr_next(lfsr_ff);

   always_comb begin
      residue_sum = '0;
      for (int i = 0; i < LW; i++) begin
         if (lfsr_nx[i]) begin
            residue_sum = SUM_W'(residue_sum + bit_weight[i]);
         end
      end
   end

   assign fill_way = mod_lut[residue_sum];

   always_comb begin
      lfsr_in = lfsr_ff;
      if (ctrl.load) begin
         lfsr_in = (ctrl.seed == '0) ? sacrr_pkg::SEED_RESET : ctrl.seed;
      end else if (ctrl.step) begin
         lfsr_in = lfsr_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= sacrr_pkg::SEED_RESET;
      end else begin
         lfsr_ff <= lfsr_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/set_assoc_cache_random_replace.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_random_replace
// Set-associative tag lookup with LFSR random replacement and hit/miss counts.
//
//   channel  dir  handshake                ports
//   req      in   req_valid / req_stall    req_address
//   rsp      out  rsp_valid / rsp_stall    rsp_hit, rsp_way_used,
//                                          rsp_hit_total, rsp_miss_total
//   csr      in   csr_wr_en                csr_wr_data (replacement seed)
//
// One transaction per cycle while neither rsp_stall nor the clearing pass
// holds the flow; the tag RAM is read at the edge that takes the request
// and the compare/update stage then loads the output register.
// After reset a clearing pass writes all 2^SET_BITS sets (64 by default)
// with req_stall high; the csr write is taken throughout.
// rsp_stall holds the output register, then the compare stage, then req.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_random_replace #(
   parameter int unsigned OFFSET_BITS  = sacrr_pkg::DEF_OFFSET_BITS,
   parameter int unsigned SET_BITS     = sacrr_pkg::DEF_SET_BITS,
   parameter int unsigned WAYS         = sacrr_pkg::DEF_WAYS,
   parameter int unsigned ADDRESS_BITS = sacrr_pkg::DEF_ADDRESS_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [sacrr_pkg::ADDR_W-1:0]        req_address,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_hit,
   output logic [sacrr_pkg::WAY_OUT_W-1:0]          rsp_way_used,
   output logic [sacrr_pkg::COUNT_W-1:0]            rsp_hit_total,
   output logic [sacrr_pkg::COUNT_W-1:0]            rsp_miss_total,
   input  wire logic                                csr_wr_en,
   input  wire logic [sacrr_pkg::SEED_W-1:0]        csr_wr_data
);

   localparam int unsigned NUM_SETS = 1 << SET_BITS;
   localparam int unsigned SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int          TAG_RAW  = int'(ADDRESS_BITS) - int'(OFFSET_BITS)
                                      - int'(SET_BITS);
   localparam int unsigned TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
   localparam int unsigned ENTRY_W  = TAG_W + 1;
   localparam int unsigned WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int unsigned CW       = sacrr_pkg::COUNT_W;
   localparam logic [SET_W-1:0] SET_MASK = SET_W'(NUM_SETS - 1);
   localparam logic [SET_W-1:0] SET_LAST = SET_W'(NUM_SETS - 1);

   // request decode
   logic [ADDRESS_BITS-1:0] addr_low;
   logic [SET_W-1:0]        req_set;
   logic [TAG_W-1:0]        req_tag;
   logic                    accept;

   // clearing pass
   logic             clr_busy_ff, clr_busy_in;
   logic [SET_W-1:0] clr_idx_ff, clr_idx_in;

   // compare stage
   logic             s1_valid_ff, s1_valid_in;
   logic [SET_W-1:0] s1_set_ff;
   logic [TAG_W-1:0] s1_tag_ff;
   logic             s1_adv;

   // last fill, seen by the transaction that read the set in the same cycle
   logic             fwd_valid_ff, fwd_valid_in;
   logic [SET_W-1:0] fwd_set_ff;
   logic [WAY_W-1:0] fwd_way_ff;
   logic [TAG_W-1:0] fwd_tag_ff;

   // tag ways
   logic [ENTRY_W-1:0] ram_rdata [WAYS];
   logic [ENTRY_W-1:0] ram_wdata;
   logic [SET_W-1:0]   ram_waddr;
   logic [WAYS-1:0]    ram_we;
   logic [WAYS-1:0]    way_match;
   logic               lookup_hit;
   logic [WAY_W-1:0]   hit_way;
   logic [WAY_W-1:0]   fill_way;
   logic               do_fill;

   sacrr_pkg::lfsr_ctrl_type lfsr_ctrl;

   // counters and output register
   logic [CW-1:0] hit_cnt_ff, hit_cnt_in;
   logic [CW-1:0] miss_cnt_ff, miss_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_hit_ff;
   logic [sacrr_pkg::WAY_OUT_W-1:0] rsp_way_ff;
   logic [CW-1:0] rsp_hit_tot_ff, rsp_miss_tot_ff;

   assign addr_low = req_address[ADDRESS_BITS-1:0];
   assign req_set  = SET_W'(addr_low >> OFFSET_BITS) & SET_MASK;
   assign req_tag  = TAG_W'(addr_low >> (OFFSET_BITS + SET_BITS));

   assign s1_adv    = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = clr_busy_ff | (s1_valid_ff & ~s1_adv);
   assign accept    = req_valid & ~req_stall;

   // ---------------------------------------------------------------- lookup
   always_comb begin
      logic [ENTRY_W-1:0] entry;
      way_match = '0;
      for (int w = 0; w < WAYS; w++) begin
         entry = ram_rdata[w];
         if (fwd_valid_ff && fwd_set_ff == s1_set_ff && fwd_way_ff == WAY_W'(w)) begin
            entry = {1'b1, fwd_tag_ff};
         end
         way_match[w] = entry[ENTRY_W-1] & (entry[TAG_W-1:0] == s1_tag_ff);
      end
   end

   always_comb begin
      hit_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (way_match[w]) begin
            hit_way = WAY_W'(w);
         end
      end
   end

   assign lookup_hit = |way_match;
   assign do_fill    = s1_adv & ~lookup_hit;

   // ------------------------------------------------------------- tag RAMs
   assign ram_waddr = clr_busy_ff ? clr_idx_ff : s1_set_ff;
   assign ram_wdata = clr_busy_ff ? '0 : {1'b1, s1_tag_ff};

   for (genvar w = 0; w < WAYS; w++) begin : g_way
      assign ram_we[w] = clr_busy_ff | (do_fill & (fill_way == WAY_W'(w)));

      sacrr_ram #(
         .DATA_W (ENTRY_W),
         .DEPTH  (NUM_SETS)
      ) u_tag_ram (
         .clock   (clock),
         .wr_en   (ram_we[w]),
         .wr_addr (ram_waddr),
         .wr_data (ram_wdata),
         .rd_en   (accept),
         .rd_addr (req_set),
         .rd_data (ram_rdata[w])
      );
   end

   // ------------------------------------------------------------ replacement
   assign lfsr_ctrl.load = csr_wr_en;
   assign lfsr_ctrl.seed = csr_wr_data;
   assign lfsr_ctrl.step = do_fill;

   sacrr_lfsr #(
      .WAYS (WAYS)
   ) u_lfsr (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (lfsr_ctrl),
      .fill_way (fill_way)
   );

   // ------------------------------------------------------------ next state
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = SET_W'(clr_idx_ff + 1'b1);
         if (clr_idx_ff == SET_LAST) begin
            clr_busy_in = 1'b0;
         end
      end

      s1_valid_in  = accept | (s1_valid_ff & ~s1_adv);
      fwd_valid_in = accept ? do_fill : fwd_valid_ff;
      rsp_valid_in = s1_adv | (rsp_valid_ff & rsp_stall);

      hit_cnt_in  = hit_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      if (s1_adv) begin
         if (lookup_hit) begin
            if (hit_cnt_ff != sacrr_pkg::COUNT_MAX) begin
               hit_cnt_in = CW'(hit_cnt_ff + 1'b1);
            end
         end else begin
            if (miss_cnt_ff != sacrr_pkg::COUNT_MAX) begin
               miss_cnt_in = CW'(miss_cnt_ff + 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_idx_ff   <= clr_idx_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_set_ff  <= req_set;
         s1_tag_ff  <= req_tag;
         fwd_set_ff <= s1_set_ff;
         fwd_way_ff <= fill_way;
         fwd_tag_ff <= s1_tag_ff;
      end
      if (s1_adv) begin
         rsp_hit_ff      <= lookup_hit;
         rsp_way_ff      <= sacrr_pkg::WAY_OUT_W'(lookup_hit ? hit_way : fill_way);
         rsp_hit_tot_ff  <= hit_cnt_in;
         rsp_miss_tot_ff <= miss_cnt_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_way_used   = rsp_way_ff;
   assign rsp_hit_total  = rsp_hit_tot_ff;
   assign rsp_miss_total = rsp_miss_tot_ff;

   // ------------------------------------------------------------ assertions
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $onehot0(way_match))
      else $error("more than one way matched");

   a_single_fill: assert property (@(posedge clock) disable iff (reset)
      !clr_busy_ff |-> $onehot0(ram_we))
      else $error("fill wrote more than one way");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !s1_valid_ff && !rsp_valid_ff)
      else $error("transaction in flight during clearing pass");

   a_miss_count: assert property (@(posedge clock) disable iff (reset)
      s1_adv && !lookup_hit && miss_cnt_ff != sacrr_pkg::COUNT_MAX |=>
         miss_cnt_ff == CW'($past(miss_cnt_ff) + 1'b1) && $stable(hit_cnt_ff))
      else $error("miss did not advance the miss count alone");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for set_assoc_cache_random_replace. A short table of
// directed accesses, then phases of random accesses under several
// replacement seeds. Typed rows are compared with their typed results and
// every other response with an in-bench tag store and LFSR, with random idle
// cycles on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned ADDR_W    = sacrr_pkg::ADDR_W;
   localparam int unsigned WAY_OUT_W = sacrr_pkg::WAY_OUT_W;
   localparam int unsigned COUNT_W   = sacrr_pkg::COUNT_W;
   localparam int unsigned SEED_W    = sacrr_pkg::SEED_W;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = sacrr_pkg::COUNT_MAX;
   localparam logic [SEED_W-1:0]  SEED_RESET = sacrr_pkg::SEED_RESET;

   localparam int OFF_W     = sacrr_pkg::DEF_OFFSET_BITS;
   localparam int SET_W     = sacrr_pkg::DEF_SET_BITS;
   localparam int WAYS      = sacrr_pkg::DEF_WAYS;
   localparam int TAG_W     = ADDR_W - OFF_W - SET_W;
   localparam int NUM_SETS  = 1 << SET_W;
   localparam int TAG_POOL  = 6;
   localparam int PHASES    = 5;
   localparam int PHASE_LEN = 286;
   localparam int DIRECTED  = 18;

   typedef struct packed {
      logic                 hit;
      logic [WAY_OUT_W-1:0] way;
      logic [COUNT_W-1:0]   hits;
      logic [COUNT_W-1:0]   misses;
   } lookup_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic              typed;
      lookup_type        result;
   } access_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [ADDR_W-1:0]    req_address;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_hit;
   logic [WAY_OUT_W-1:0] rsp_way_used;
   logic [COUNT_W-1:0]   rsp_hit_total;
   logic [COUNT_W-1:0]   rsp_miss_total;
   logic                 csr_wr_en;
   logic [SEED_W-1:0]    csr_wr_data;

   // bench copy of the cache state
   logic [TAG_W-1:0]   line_tag   [NUM_SETS][WAYS];
   logic               line_valid [NUM_SETS][WAYS];
   logic [SEED_W-1:0]  replace_state;
   logic [COUNT_W-1:0] hit_count;
   logic [COUNT_W-1:0] miss_count;

   lookup_type       expected_lookups[$];
   int               mismatch_count = 0;
   int               send_mode = 0;
   int               recv_mode = 0;
   int               sent_count = 0;
   int               recv_count = 0;
   logic [TAG_W-1:0] tag_pool [TAG_POOL];
   logic [SET_W-1:0] window_base;

   // rows typed in are read straight off a fresh cache with seed 1
   access_row_type directed_accesses [DIRECTED] = '{
      '{32'h0000_0000, 1'b1, '{1'b0, 2'd0, 32'd0, 32'd1}},
      '{32'h0000_0000, 1'b1, '{1'b1, 2'd0, 32'd1, 32'd1}},
      '{32'hFFFF_FFFF, 1'b1, '{1'b0, 2'd0, 32'd1, 32'd2}},
      '{32'hFFFF_FFE0, 1'b1, '{1'b1, 2'd0, 32'd2, 32'd2}},
      '{32'h0000_001F, 1'b1, '{1'b1, 2'd0, 32'd3, 32'd2}},
      '{32'h8000_0000, 1'b0, '0},
      '{32'h0000_07E0, 1'b0, '0},
      '{32'h0000_0800, 1'b0, '0},
      '{32'h0000_1000, 1'b0, '0},
      '{32'h0000_1800, 1'b0, '0},
      '{32'h0000_2000, 1'b0, '0},
      '{32'h0000_0000, 1'b0, '0},
      '{32'hAAAA_AAAA, 1'b0, '0},
      '{32'h5555_5555, 1'b0, '0},
      '{32'hAAAA_AAAA, 1'b0, '0},
      '{32'h5555_5555, 1'b0, '0},
      '{32'h7FFF_FFFF, 1'b0, '0},
      '{32'hFFFF_F800, 1'b0, '0}
   };

   set_assoc_cache_random_replace uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_address    (req_address),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_way_used   (rsp_way_used),
      .rsp_hit_total  (rsp_hit_total),
      .rsp_miss_total (rsp_miss_total),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("Verification failed");
      $finish;
   end

   // 0: back to back, 1: long gaps, 2: short gaps
   function automatic int draw_wait(input int mode);
      case (mode)
         0: return 0;
         1: return $urandom_range(0, 19);
         default: return $urandom_range(0, 3);
      endcase
   endfunction

   function automatic lookup_type predict_lookup(input logic [ADDR_W-1:0] address);
      logic [SET_W-1:0] set_idx;
      logic [TAG_W-1:0] tag;
      lookup_type       r;
      bit               found;
      int               w;
      int               victim;
      set_idx = address[OFF_W +: SET_W];
      tag     = address[ADDR_W-1 -: TAG_W];
      found   = 1'b0;
      r       = '0;
      // scan downward so the lowest matching way wins
      for (w = WAYS - 1; w >= 0; w--) begin
         if (line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
            found = 1'b1;
            r.way = WAY_OUT_W'(w);
         end
      end
      if (found) begin
         if (hit_count != COUNT_MAX) hit_count++;
         r.hit = 1'b1;
      end else begin
         if (miss_count != COUNT_MAX) miss_count++;
         replace_state = {replace_state[0] ^ replace_state[2] ^ replace_state[3]
                          ^ replace_state[5], replace_state[SEED_W-1:1]};
         victim = int'(replace_state) % WAYS;
         line_tag[set_idx][victim]   = tag;
         line_valid[set_idx][victim] = 1'b1;
         r.way = WAY_OUT_W'(victim);
      end
      r.hits   = hit_count;
      r.misses = miss_count;
      return r;
   endfunction

   // mostly a small tag pool over a few sets so lines get reused and evicted
   function automatic logic [ADDR_W-1:0] pick_address();
      logic [SET_W-1:0] s;
      logic [TAG_W-1:0] t;
      logic [OFF_W-1:0] o;
      if ($urandom_range(0, 9) == 0) return $urandom;
      t = tag_pool[$urandom_range(0, TAG_POOL - 1)];
      if ($urandom_range(0, 9) < 7) s = SET_W'(window_base + $urandom_range(0, 3));
      else s = SET_W'($urandom);
      o = OFF_W'($urandom);
      return {t, s, o};
   endfunction

   task automatic send_access(input logic [ADDR_W-1:0] address, input logic typed,
                              input lookup_type typed_result);
      int         gap;
      lookup_type predicted;
      gap = draw_wait(send_mode);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_address <= address;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = predict_lookup(address);
      expected_lookups.push_back(typed ? typed_result : predicted);
      sent_count++;
      if (sent_count % 32 == 0) send_mode = $urandom_range(0, 2);
   endtask

   task automatic drain_lookups();
      while (expected_lookups.size() != 0) @(posedge clock);
      // pipeline is two deep
      repeat (4) @(posedge clock);
   endtask

   task automatic write_seed(input logic [SEED_W-1:0] seed);
      int i;
      req_valid <= 1'b0;
      drain_lookups();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= seed;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      replace_state = (seed == '0) ? SEED_RESET : seed;
      for (i = 0; i < TAG_POOL; i++) tag_pool[i] = TAG_W'($urandom);
      window_base = SET_W'($urandom);
   endtask

   // stimulus
   initial begin
      int          i;
      int          p;
      logic [SEED_W-1:0] seed;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_address <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      foreach (line_valid[s, w]) begin
         line_valid[s][w] = 1'b0;
         line_tag[s][w]   = '0;
      end
      replace_state = SEED_RESET;
      hit_count     = '0;
      miss_count    = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED; i++)
         send_access(directed_accesses[i].address, directed_accesses[i].typed,
                     directed_accesses[i].result);

      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: seed = 16'hFFFF;
            1: seed = 16'h0000;   // zero seed loads as one
            3: seed = 16'h0001;
            default: seed = SEED_W'($urandom_range(1, 65535));
         endcase
         write_seed(seed);
         for (i = 0; i < PHASE_LEN; i++) send_access(pick_address(), 1'b0, '0);
      end

      req_valid <= 1'b0;
      drain_lookups();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // response side
   initial begin
      int         pause;
      lookup_type got;
      lookup_type want;
      forever begin
         pause = draw_wait(recv_mode);
         if (pause > 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1 || reset);
         got = '{rsp_hit, rsp_way_used, rsp_hit_total, rsp_miss_total};
         if (expected_lookups.size() == 0) begin
            $display("%0t: unexpected transaction hit=%0d way=%0d hits=%0d misses=%0d",
                     $time, got.hit, got.way, got.hits, got.misses);
            mismatch_count++;
         end else begin
            want = expected_lookups.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected hit=%0d way=%0d hits=%0d misses=%0d",
                        $time, want.hit, want.way, want.hits, want.misses);
               $display("%0t:          actual   hit=%0d way=%0d hits=%0d misses=%0d",
                        $time, got.hit, got.way, got.hits, got.misses);
               mismatch_count++;
            end
         end
         recv_count++;
         if (recv_count % 32 == 0) recv_mode = $urandom_range(0, 2);
      end
   end

endmodule
